// ===== src/interval_lane_depth_assigner_macros.svh =====
// Assertion macros for the interval lane depth assigner
`ifndef INTERVAL_LANE_DEPTH_ASSIGNER_MACROS_SVH
`define INTERVAL_LANE_DEPTH_ASSIGNER_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, c, r, p) \
  lbl: assert property (@(posedge c) disable iff (r) (p)) else $error("assertion failed");
`define ASSERT_IMPLY(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |-> (b)) else $error("assertion failed");
`define ASSERT_NEXT(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |=> (b)) else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, c, r, p)
`define ASSERT_IMPLY(lbl, c, r, a, b)
`define ASSERT_NEXT(lbl, c, r, a, b)
`endif
`endif

// ===== src/ilda_pkg.sv =====
// Shared constants and types for the interval lane depth assigner
package ilda_pkg;
  localparam int DEPTH_W = 6;
  localparam int TIME_W = 64;
  localparam int ID_W = 64;
  localparam int MAX_DEPTH_DEFAULT = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK
  } state_t;
endpackage

// ===== src/interval_lane_depth_assigner.sv =====
// Used lanes are scanned from lane 0 up, through ST_READ then ST_CHECK for each; the first lane
// whose stored end lies before start_time is reused, else a new lane opens, or overflow is flagged.
// A new item is taken only in idle, once the previous one is done; the single read port serialises it.
// Used lanes always form a prefix, tracked by a fill count; no memory clearing pass.
// Reset (rst, synchronous) clears the fill count, track maximum, state and result strobe.
// valid is a one-cycle strobe; the receiver cannot stall it.
`include "interval_lane_depth_assigner_macros.svh"
module interval_lane_depth_assigner #(
  parameter int MAX_DEPTH = ilda_pkg::MAX_DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          new_track,
  input  logic [ilda_pkg::ID_W-1:0]     slice_id,
  input  logic [ilda_pkg::TIME_W-1:0]   start_time,
  input  logic [ilda_pkg::TIME_W-1:0]   end_time,
  output logic                          valid,
  output logic [ilda_pkg::ID_W-1:0]     result_id,
  output logic [ilda_pkg::DEPTH_W-1:0]  depth,
  output logic [ilda_pkg::DEPTH_W-1:0]  max_depth,
  output logic                          overflow
);
  localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CW = $clog2(MAX_DEPTH + 1);
  localparam int DW = ilda_pkg::DEPTH_W;
  localparam logic [CW-1:0] FULL = CW'(MAX_DEPTH);

  ilda_pkg::state_t state, state_next;

  logic [ilda_pkg::TIME_W-1:0] lane_mem [MAX_DEPTH];
  logic [ilda_pkg::TIME_W-1:0] rdata;
  logic                        mem_we;
  logic [ilda_pkg::TIME_W-1:0] wdata;

  logic [CW-1:0]               idx, idx_next;
  logic [CW-1:0]               fill, fill_next;
  logic [DW-1:0]               track_max, track_max_next;
  logic [ilda_pkg::ID_W-1:0]   s_id;
  logic [ilda_pkg::TIME_W-1:0] s_start;
  logic [ilda_pkg::TIME_W-1:0] s_end;

  logic                        valid_next;
  logic [DW-1:0]               depth_next;
  logic [DW-1:0]               max_depth_next;
  logic                        overflow_next;

  logic [CW+DW-1:0]            idx_ext;
  logic [DW-1:0]               pick;

  assign idx_ext = {{DW{1'b0}}, idx};
  assign pick = idx_ext[DW-1:0];
  assign busy = (state != ilda_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lane_mem[idx[IW-1:0]] <= wdata;
    end
    rdata <= lane_mem[idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s_id    <= slice_id;
      s_start <= start_time;
      s_end   <= end_time;
    end
    result_id <= s_id;
    depth     <= depth_next;
    max_depth <= max_depth_next;
    overflow  <= overflow_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ilda_pkg::ST_IDLE;
      idx       <= '0;
      fill      <= '0;
      track_max <= '0;
      valid     <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      fill      <= fill_next;
      track_max <= track_max_next;
      valid     <= valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    fill_next      = fill;
    track_max_next = track_max;
    valid_next     = 1'b0;
    depth_next     = depth;
    max_depth_next = max_depth;
    overflow_next  = overflow;
    mem_we         = 1'b0;
    wdata          = s_end;
    case (state)
      ilda_pkg::ST_IDLE: begin
        if (start) begin
          idx_next   = '0;
          state_next = ilda_pkg::ST_READ;
          if (new_track) begin
            fill_next      = '0;
            track_max_next = '0;
          end
        end
      end
      ilda_pkg::ST_READ: begin
        if (idx == fill) begin
          state_next = ilda_pkg::ST_IDLE;
          valid_next = 1'b1;
          if (fill == FULL) begin
            depth_next     = '0;
            max_depth_next = track_max;
            overflow_next  = 1'b1;
          end else begin
            mem_we         = 1'b1;
            wdata          = s_end;
            fill_next      = fill + CW'(1);
            depth_next     = pick;
            max_depth_next = (pick > track_max) ? pick : track_max;
            track_max_next = max_depth_next;
            overflow_next  = 1'b0;
          end
        end else begin
          state_next = ilda_pkg::ST_CHECK;
        end
      end
      ilda_pkg::ST_CHECK: begin
        if (rdata < s_start) begin
          mem_we         = 1'b1;
          wdata          = (s_end > rdata) ? s_end : rdata;
          state_next     = ilda_pkg::ST_IDLE;
          valid_next     = 1'b1;
          depth_next     = pick;
          max_depth_next = (pick > track_max) ? pick : track_max;
          track_max_next = max_depth_next;
          overflow_next  = 1'b0;
        end else begin
          idx_next   = idx + CW'(1);
          state_next = ilda_pkg::ST_READ;
        end
      end
      default: begin
        state_next = ilda_pkg::ST_IDLE;
      end
    endcase
  end

  `ASSERT_ALWAYS(a_fill_bound, clk, rst, fill <= FULL)
  `ASSERT_ALWAYS(a_idx_bound, clk, rst, idx <= fill)
  `ASSERT_IMPLY(a_depth_le_max, clk, rst, valid && !overflow, depth <= max_depth)
  `ASSERT_IMPLY(a_ovf_depth, clk, rst, valid && overflow, depth == '0)
  `ASSERT_NEXT(a_valid_single, clk, rst, valid, !valid)
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !valid)
endmodule
